// ----- src/assert_macros.svh -----
// Assertion macros used by the tile decoder controller.
// Depends on nothing; clk_i and rst_ni must exist where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PRTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define PRTD_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define PRTD_ASSERT(lbl, prop, msg)
`define PRTD_NEVER(lbl, expr, msg)
`endif
`endif

// ----- src/prtd_pkg.sv -----
// Types and constants of the palette run-length tile decoder.
// Used by the controller, the datapath and the top level.
package prtd_pkg;

  localparam int unsigned RING_DEPTH = 12;
  localparam logic [23:0] WHITE = 24'hFFFFFF;
  localparam logic [10:0] EXT2_LIMIT = 11'd267;
  localparam logic [3:0] KIND_WHITE = 4'd12;
  localparam logic [3:0] KIND_COLOUR = 4'd13;
  localparam logic [3:0] KIND_COPY = 4'd14;
  localparam logic [1:0] FMT_GRAY = 2'd0;
  localparam logic [1:0] FMT_PACK12 = 2'd1;
  localparam logic [1:0] FMT_RGB = 2'd2;

  typedef struct packed {
    logic accept;
    logic rd;
    logic pix;
    logic trunc;
  } prtd_cmd_t;

  typedef struct packed {
    logic start_run;
    logic copy;
    logic last_px;
    logic out_free;
    logic tile_over;
  } prtd_stat_t;

endpackage

// ----- src/prtd_ctrl.sv -----
// Sequencer of the tile decoder: byte intake, pixel emission, truncation report.
// Depends on prtd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module prtd_ctrl import prtd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       msg_end_i,
  output logic       in_ready_o,
  input  prtd_stat_t st_i,
  output prtd_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD = 2'd1;
  localparam logic [1:0] S_PIX = 2'd2;
  localparam logic [1:0] S_TRUNC = 2'd3;

  logic [1:0] state_q, state_d;
  logic       mend_q, mend_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    mend_d = mend_q;
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          mend_d = msg_end_i;
          if (st_i.start_run) begin
            state_d = st_i.copy ? S_RD : S_PIX;
          end else if (msg_end_i) begin
            state_d = S_TRUNC;
          end
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d = S_PIX;
      end
      S_PIX: begin
        if (st_i.out_free) begin
          cmd_o.pix = 1'b1;
          if (!st_i.last_px) begin
            state_d = st_i.copy ? S_RD : S_PIX;
          end else begin
            state_d = mend_q ? S_TRUNC : S_IDLE;
          end
        end
      end
      S_TRUNC: begin
        if (st_i.tile_over) begin
          state_d = S_IDLE;
        end else if (st_i.out_free) begin
          cmd_o.trunc = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mend_q <= mend_d;
    end
  end

  `PRTD_ASSERT(a_pix_needs_room, cmd_o.pix |-> st_i.out_free, "pixel loaded into busy output")
  `PRTD_ASSERT(a_rd_then_pix, state_q == S_RD |=> state_q == S_PIX, "read not followed by pixel")
  `PRTD_NEVER(a_pix_trunc, cmd_o.pix && cmd_o.trunc, "pixel and truncation in one cycle")
  `PRTD_ASSERT(a_run_starts, (cmd_o.accept && st_i.start_run) |=>
               (state_q == S_RD || state_q == S_PIX), "run accepted but not emitted")

endmodule

// ----- src/prtd_datapath.sv -----
// Datapath of the tile decoder: header and colour decode, ring, tile store, output register.
// Depends on prtd_pkg; driven by prtd_ctrl.
module prtd_datapath import prtd_pkg::*; #(
  parameter int unsigned TILE_EDGE = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  byte_i,
  input  logic        tile_start_i,
  input  logic [3:0]  width_i,
  input  logic [3:0]  height_i,
  input  logic [1:0]  format_i,
  input  prtd_cmd_t   cmd_i,
  output prtd_stat_t  st_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [23:0] out_colour_o,
  output logic [5:0]  out_index_o,
  output logic        out_done_o,
  output logic        out_trunc_o
);

  localparam int unsigned STORE_DEPTH = TILE_EDGE * TILE_EDGE;
  localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);
  localparam int unsigned POS_W = ADDR_W + 1;
  localparam logic [3:0] EDGE4 = 4'(TILE_EDGE);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_EXT1 = 3'd1;
  localparam logic [2:0] PH_EXT2 = 3'd2;
  localparam logic [2:0] PH_COLOUR = 3'd3;
  localparam logic [2:0] PH_LITERAL = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;

  logic [3:0]       width_q, height_q, width_d, height_d;
  logic [1:0]       fmt_q, fmt_d;
  logic [POS_W-1:0] pos_q, pos_d, stop_q, stop_d;
  logic [3:0]       kind_q, kind_d;
  logic [10:0]      ls_q, ls_d;
  logic [2:0]       phase_q, phase_d;
  logic [15:0]      held_q, held_d;
  logic [1:0]       cnt_q, cnt_d;
  logic [3:0]       ptr_q, ptr_d;
  logic [23:0]      colour_q, colour_d;
  logic             copy_q, copy_d, single_q, single_d, above_q;
  logic [23:0]      rdata_q;
  logic [23:0]      ring_q [RING_DEPTH];
  logic [23:0]      store_q [STORE_DEPTH];
  logic             ring_we, begin_run, run_go;
  logic [23:0]      ring_rd;
  logic [POS_W-1:0] area_e, area_c;
  logic [11:0]      stop_sum;
  logic [1:0]       need_m1;
  logic [7:0]       b0, b1;
  logic [POS_W-1:0] pos_nx;
  logic             run_end;
  logic [23:0]      px_colour;
  logic             out_valid_q, out_done_q, out_trunc_q;
  logic [23:0]      out_colour_q;
  logic [5:0]       out_index_q;
  logic [6:0]       pos_pad;

  function automatic logic [3:0] clamp_dim(input logic [3:0] v);
    logic [3:0] r;
    r = v;
    if (v == 4'd0) r = 4'd1;
    else if (v > EDGE4) r = EDGE4;
    return r;
  endfunction

  function automatic logic [23:0] pack12(input logic [3:0] r, input logic [3:0] g,
                                         input logic [3:0] b);
    return {b, b, g, g, r, r};
  endfunction

  assign area_c = POS_W'(width_q) * POS_W'(height_q);
  assign b0 = held_q[7:0];
  assign b1 = held_q[15:8];

  always_comb begin
    width_d = width_q;
    height_d = height_q;
    fmt_d = fmt_q;
    pos_d = pos_q;
    kind_d = kind_q;
    ls_d = ls_q;
    phase_d = phase_q;
    held_d = held_q;
    cnt_d = cnt_q;
    ptr_d = ptr_q;
    colour_d = colour_q;
    copy_d = 1'b0;
    single_d = 1'b0;
    ring_we = 1'b0;
    begin_run = 1'b0;
    run_go = 1'b0;
    if (tile_start_i) begin
      width_d = clamp_dim(width_i);
      height_d = clamp_dim(height_i);
      fmt_d = (format_i > FMT_RGB) ? FMT_RGB : format_i;
      pos_d = '0;
      kind_d = '0;
      ls_d = '0;
      phase_d = PH_HEADER;
      held_d = '0;
      cnt_d = '0;
      ptr_d = '0;
    end
    area_e = POS_W'(width_d) * POS_W'(height_d);
    need_m1 = fmt_d;
    unique case (phase_d)
      PH_HEADER: begin
        kind_d = byte_i[3:0];
        ls_d = 11'(byte_i[7:4]);
        if (byte_i[7:4] == 4'hF) phase_d = PH_EXT1;
        else begin_run = 1'b1;
      end
      PH_EXT1: begin
        ls_d = ls_d + 11'(byte_i);
        if (ls_d >= EXT2_LIMIT) phase_d = PH_EXT2;
        else begin_run = 1'b1;
      end
      PH_EXT2: begin
        ls_d = ls_d + {1'b0, byte_i, 2'b00};
        begin_run = 1'b1;
      end
      PH_COLOUR: begin
        if (cnt_d < need_m1) begin
          if (cnt_d == 2'd0) held_d[7:0] = byte_i;
          else held_d[15:8] = byte_i;
          cnt_d = cnt_d + 2'd1;
        end else begin
          case (fmt_d)
            FMT_GRAY: colour_d = {byte_i, byte_i, byte_i};
            FMT_PACK12: colour_d = pack12(held_d[3:0], held_d[7:4], byte_i[3:0]);
            default: colour_d = {byte_i, held_d};
          endcase
          ring_we = 1'b1;
          ptr_d = (ptr_d == 4'(RING_DEPTH - 1)) ? 4'd0 : ptr_d + 4'd1;
          held_d = '0;
          cnt_d = '0;
          run_go = 1'b1;
        end
      end
      PH_LITERAL: begin
        case (fmt_d)
          FMT_GRAY: begin
            colour_d = {byte_i, byte_i, byte_i};
            single_d = 1'b1;
          end
          FMT_PACK12: begin
            if (cnt_d == 2'd0) begin
              held_d = {8'h00, byte_i};
              cnt_d = 2'd1;
            end else if (cnt_d == 2'd1) begin
              colour_d = pack12(held_d[3:0], held_d[7:4], byte_i[3:0]);
              held_d = {byte_i, 8'h00};
              cnt_d = 2'd2;
              single_d = 1'b1;
            end else begin
              colour_d = pack12(held_d[15:12], byte_i[3:0], byte_i[7:4]);
              held_d = '0;
              cnt_d = '0;
              single_d = 1'b1;
            end
          end
          default: begin
            if (cnt_d < 2'd2) begin
              if (cnt_d == 2'd0) held_d[7:0] = byte_i;
              else held_d[15:8] = byte_i;
              cnt_d = cnt_d + 2'd1;
            end else begin
              colour_d = {byte_i, held_d};
              held_d = '0;
              cnt_d = '0;
              single_d = 1'b1;
            end
          end
        endcase
        run_go = single_d;
      end
      default: ;
    endcase
    ring_rd = tile_start_i ? 24'h0 : ring_q[kind_d];
    stop_sum = {1'b0, ls_d} + 12'(pos_d);
    stop_d = stop_q;
    if (begin_run) begin
      stop_d = (ls_d == 11'd0 || stop_sum > 12'(area_e)) ? area_e : POS_W'(stop_sum);
      held_d = '0;
      cnt_d = '0;
      if (kind_d < KIND_WHITE) begin
        colour_d = ring_rd;
        run_go = 1'b1;
      end else if (kind_d == KIND_WHITE) begin
        colour_d = WHITE;
        run_go = 1'b1;
      end else if (kind_d == KIND_COLOUR) begin
        phase_d = PH_COLOUR;
      end else if (kind_d == KIND_COPY) begin
        copy_d = 1'b1;
        run_go = 1'b1;
      end else begin
        phase_d = PH_LITERAL;
      end
    end
  end

  assign pos_nx = pos_q + POS_W'(1);
  assign run_end = (pos_nx >= stop_q);
  assign px_colour = copy_q ? (above_q ? rdata_q : WHITE) : colour_q;
  assign st_o.start_run = run_go;
  assign st_o.copy = cmd_i.accept ? copy_d : copy_q;
  assign st_o.last_px = single_q || run_end;
  assign st_o.out_free = !out_valid_q || out_ready_i;
  assign st_o.tile_over = (phase_q == PH_DONE);
  assign pos_pad = 7'(pos_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 4'd1;
      height_q <= 4'd1;
      fmt_q <= FMT_GRAY;
      pos_q <= '0;
      stop_q <= '0;
      kind_q <= '0;
      ls_q <= '0;
      phase_q <= PH_HEADER;
      held_q <= '0;
      cnt_q <= '0;
      ptr_q <= '0;
      copy_q <= 1'b0;
      single_q <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < RING_DEPTH; i++) ring_q[i] <= '0;
    end else begin
      if (cmd_i.accept) begin
        width_q <= width_d;
        height_q <= height_d;
        fmt_q <= fmt_d;
        pos_q <= pos_d;
        stop_q <= stop_d;
        kind_q <= kind_d;
        ls_q <= ls_d;
        phase_q <= phase_d;
        held_q <= held_d;
        cnt_q <= cnt_d;
        ptr_q <= ptr_d;
        copy_q <= copy_d;
        single_q <= single_d;
        if (tile_start_i) begin
          for (int i = 0; i < RING_DEPTH; i++) ring_q[i] <= '0;
        end else if (ring_we) begin
          ring_q[ptr_q] <= colour_d;
        end
      end else if (cmd_i.pix) begin
        pos_q <= pos_nx;
        if (run_end) begin
          phase_q <= (pos_nx >= area_c) ? PH_DONE : PH_HEADER;
          held_q <= '0;
          cnt_q <= '0;
        end
      end else if (cmd_i.trunc) begin
        phase_q <= PH_DONE;
      end
      if (cmd_i.pix || cmd_i.trunc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) colour_q <= colour_d;
    if (cmd_i.rd) begin
      above_q <= (pos_q >= POS_W'(width_q));
      rdata_q <= store_q[ADDR_W'(pos_q - POS_W'(width_q))];
    end
    if (cmd_i.pix) begin
      store_q[pos_q[ADDR_W-1:0]] <= px_colour;
      out_colour_q <= px_colour;
      out_index_q <= pos_pad[5:0];
      out_done_q <= (pos_nx >= area_c);
      out_trunc_q <= 1'b0;
    end else if (cmd_i.trunc) begin
      out_colour_q <= '0;
      out_index_q <= pos_pad[5:0];
      out_done_q <= 1'b0;
      out_trunc_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_colour_o = out_colour_q;
  assign out_index_o = out_index_q;
  assign out_done_o = out_done_q;
  assign out_trunc_o = out_trunc_q;

endmodule

// ----- src/palette_run_length_tile_decoder_core.sv -----
// Takes one byte per cycle while idle (no pixels or truncation report pending); a run
// emits one pixel a cycle unless the output stalls; copy-from-above runs read the tile
// store in a state of its own before each pixel. A run's pixels leave through the
// output register; a truncation report follows the last pixel of the byte.
// Asynchronous active-low reset clears control state and the colour ring; the tile
// store has no reset.
module palette_run_length_tile_decoder_core import prtd_pkg::*; #(
  parameter int unsigned TILE_EDGE = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // data_byte[7:0], tile_width[11:8], tile_height[15:12], colour_format[17:16], unused
  input  logic [23:0] s_axis_tdata_i,
  // tile_start
  input  logic        s_axis_tuser_i,
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // pixel_colour[23:0], pixel_index[29:24], zero
  output logic [31:0] m_axis_tdata_o,
  // truncated
  output logic        m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  prtd_cmd_t  cmd;
  prtd_stat_t st;
  logic [23:0] colour;
  logic [5:0]  index;

  prtd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .msg_end_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  prtd_datapath #(.TILE_EDGE(TILE_EDGE)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (s_axis_tdata_i[7:0]),
    .tile_start_i (s_axis_tuser_i),
    .width_i      (s_axis_tdata_i[11:8]),
    .height_i     (s_axis_tdata_i[15:12]),
    .format_i     (s_axis_tdata_i[17:16]),
    .cmd_i        (cmd),
    .st_o         (st),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_colour_o (colour),
    .out_index_o  (index),
    .out_done_o   (m_axis_tlast_o),
    .out_trunc_o  (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {2'b00, index, colour};

endmodule
